// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked property, checked during reset too
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/ppq_pkg.sv -----
// ----------------------------------------------------------------------------
// ppq_pkg
// Shared constants, codes and command types of the priority task queue.
// ----------------------------------------------------------------------------
package ppq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NEST_DEPTH  = 8;
   localparam int PRIO_BITS   = 8;

   // stored priority width: the request port carries eight bits
   localparam int PRIO_W  = (PRIO_BITS < 8) ? PRIO_BITS : 8;
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_W = $clog2(NEST_DEPTH + 1);
   localparam int SIDX_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

   typedef enum logic [1:0] {
      REQ_ADD      = 2'd0,
      REQ_DISPATCH = 2'd1,
      REQ_FINISH   = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_QUEUE_FULL = 2'd1,
      ST_STACK_FULL = 2'd2,
      ST_NONE_RUN   = 2'd3
   } status_code_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// ----- hw/rtl/ppq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppq_ctrl
// Sequencer: captures a request, commits it to the datapath when the
// result register is free, and runs the result handshake.
// ----------------------------------------------------------------------------
module ppq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppq_pkg::cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      commit;

   assign req_ready   = (state_ff == S_IDLE);
   assign commit      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = commit;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/ppq_dpath.sv -----
// ----------------------------------------------------------------------------
// ppq_dpath
// Sorted shift-cell task queue, nesting stack of running priorities and
// the result register.
// ----------------------------------------------------------------------------
module ppq_dpath (
   input  logic             clock,
   input  logic             reset,
   input  ppq_pkg::cmd_type cmd,
   input  logic [1:0]       req_type,
   input  logic [15:0]      req_callback_id,
   input  logic [31:0]      req_task_argument,
   input  logic [7:0]       req_task_priority,
   output logic [1:0]       rsp_status,
   output logic             rsp_dispatched,
   output logic [15:0]      rsp_out_callback,
   output logic [31:0]      rsp_out_argument,
   output logic [7:0]       rsp_out_priority,
   output logic [4:0]       rsp_pending_count,
   output logic [3:0]       rsp_nest_depth
);

   localparam int QD = ppq_pkg::QUEUE_DEPTH;
   localparam int ND = ppq_pkg::NEST_DEPTH;
   localparam int PW = ppq_pkg::PRIO_W;
   localparam int FW = ppq_pkg::FILL_W;
   localparam int LW = ppq_pkg::LEVEL_W;
   localparam int SW = ppq_pkg::SIDX_W;

   // captured request
   ppq_pkg::req_code_type op_ff;
   logic [15:0]           cb_ff;
   logic [31:0]           arg_ff;
   logic [PW-1:0]         prio_ff;

   // queue cells
   logic [PW-1:0] q_prio_ff [QD];
   logic [15:0]   q_cb_ff   [QD];
   logic [31:0]   q_arg_ff  [QD];
   logic [FW-1:0] fill_ff, fill_in;

   // nesting stack
   logic [PW-1:0] stack_ff [ND];
   logic [LW-1:0] level_ff, level_in;
   logic [PW-1:0] top_prio;

   // result register
   ppq_pkg::status_code_type status_ff, status_in;
   logic                     disp_ff, disp_in;
   logic [15:0]              ocb_ff;
   logic [31:0]              oarg_ff;
   logic [7:0]               oprio_ff;
   logic [4:0]               pend_ff;
   logic [3:0]               depth_ff;

   logic          valid    [QD];
   logic          stay     [QD];
   logic          do_insert;
   logic          do_pop;
   logic          eligible;

   assign top_prio = stack_ff[SW'(level_ff - LW'(1))];
   assign eligible = (level_ff == '0) || (q_prio_ff[0] < top_prio);

   always_comb begin
      for (int i = 0; i < QD; i++) begin
         valid[i] = (FW'(i) < fill_ff);
         stay[i]  = valid[i] && !(prio_ff < q_prio_ff[i]);
      end
   end

   always_comb begin
      status_in = ppq_pkg::ST_OK;
      disp_in   = 1'b0;
      do_insert = 1'b0;
      do_pop    = 1'b0;
      fill_in   = fill_ff;
      level_in  = level_ff;
      case (op_ff)
         ppq_pkg::REQ_ADD: begin
            if (fill_ff >= FW'(QD)) begin
               status_in = ppq_pkg::ST_QUEUE_FULL;
            end else begin
               do_insert = 1'b1;
               fill_in   = fill_ff + FW'(1);
            end
         end
         ppq_pkg::REQ_DISPATCH: begin
            if ((fill_ff != '0) && eligible) begin
               if (level_ff >= LW'(ND)) begin
                  status_in = ppq_pkg::ST_STACK_FULL;
               end else begin
                  disp_in  = 1'b1;
                  do_pop   = 1'b1;
                  fill_in  = fill_ff - FW'(1);
                  level_in = level_ff + LW'(1);
               end
            end
         end
         ppq_pkg::REQ_FINISH: begin
            if (level_ff == '0) begin
               status_in = ppq_pkg::ST_NONE_RUN;
            end else begin
               level_in = level_ff - LW'(1);
            end
         end
         default: begin
            status_in = ppq_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= ppq_pkg::req_code_type'(req_type);
         cb_ff   <= req_callback_id;
         arg_ff  <= req_task_argument;
         prio_ff <= req_task_priority[PW-1:0];
      end
   end

   // insert: cells ahead of the new task hold, the slot takes it, the rest advance
   always_ff @(posedge clock) begin
      if (cmd.commit && do_insert) begin
         for (int i = 0; i < QD; i++) begin
            if (!stay[i]) begin
               if (i == 0) begin
                  q_prio_ff[i] <= prio_ff;
                  q_cb_ff[i]   <= cb_ff;
                  q_arg_ff[i]  <= arg_ff;
               end else if (stay[(i > 0) ? i - 1 : 0]) begin
                  q_prio_ff[i] <= prio_ff;
                  q_cb_ff[i]   <= cb_ff;
                  q_arg_ff[i]  <= arg_ff;
               end else begin
                  q_prio_ff[i] <= q_prio_ff[(i > 0) ? i - 1 : 0];
                  q_cb_ff[i]   <= q_cb_ff[(i > 0) ? i - 1 : 0];
                  q_arg_ff[i]  <= q_arg_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end
      end else if (cmd.commit && do_pop) begin
         for (int i = 0; i < QD - 1; i++) begin
            q_prio_ff[i] <= q_prio_ff[i + 1];
            q_cb_ff[i]   <= q_cb_ff[i + 1];
            q_arg_ff[i]  <= q_arg_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_pop) begin
         stack_ff[SW'(level_ff)] <= q_prio_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         level_ff <= '0;
      end else if (cmd.commit) begin
         fill_ff  <= fill_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         disp_ff   <= disp_in;
         ocb_ff    <= disp_in ? q_cb_ff[0]           : 16'd0;
         oarg_ff   <= disp_in ? q_arg_ff[0]          : 32'd0;
         oprio_ff  <= disp_in ? 8'(q_prio_ff[0])     : 8'd0;
         pend_ff   <= 5'(fill_in);
         depth_ff  <= 4'(level_in);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_dispatched    = disp_ff;
   assign rsp_out_callback  = ocb_ff;
   assign rsp_out_argument  = oarg_ff;
   assign rsp_out_priority  = oprio_ff;
   assign rsp_pending_count = pend_ff;
   assign rsp_nest_depth    = depth_ff;

endmodule

// ----- hw/rtl/preemptive_priority_task_queue.sv -----
// A request is accepted in the idle state, captured, and committed from the
// execute state once the result register is free; the result is then registered.
// The sequencer takes no new request until the current one is committed.
// A stalled result holds the commit of the following request.
// Reset (synchronous, active high) empties the queue and the nesting stack
// at once; queued entries and stack slots need no clearing.
// ----------------------------------------------------------------------------
// preemptive_priority_task_queue
// Bottom-half task scheduler with a sorted pending queue and a nesting
// stack of running priorities.
// ----------------------------------------------------------------------------
module preemptive_priority_task_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_callback_id,
   input  logic [31:0] req_task_argument,
   input  logic [7:0]  req_task_priority,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_dispatched,
   output logic [15:0] rsp_out_callback,
   output logic [31:0] rsp_out_argument,
   output logic [7:0]  rsp_out_priority,
   output logic [4:0]  rsp_pending_count,
   output logic [3:0]  rsp_nest_depth
);

   ppq_pkg::cmd_type cmd;

   ppq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ppq_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_type          (req_type),
      .req_callback_id   (req_callback_id),
      .req_task_argument (req_task_argument),
      .req_task_priority (req_task_priority),
      .rsp_status        (rsp_status),
      .rsp_dispatched    (rsp_dispatched),
      .rsp_out_callback  (rsp_out_callback),
      .rsp_out_argument  (rsp_out_argument),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_pending_count (rsp_pending_count),
      .rsp_nest_depth    (rsp_nest_depth)
   );

endmodule

// ----- hw/rtl/ppq_checker.sv -----
// ----------------------------------------------------------------------------
// ppq_checker
// Port-level checks of the priority task queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_dispatched,
   input logic [15:0] rsp_out_callback,
   input logic [31:0] rsp_out_argument,
   input logic [7:0]  rsp_out_priority,
   input logic [4:0]  rsp_pending_count,
   input logic [3:0]  rsp_nest_depth
);

   logic        stalled;
   logic [67:0] rsp_word;
   logic        idle_zero;
   logic        dispatch_ok;
   logic        counts_ok;

   assign stalled     = rsp_valid && !rsp_ready;
   assign rsp_word    = {rsp_status, rsp_dispatched, rsp_out_callback, rsp_out_argument,
                         rsp_out_priority, rsp_pending_count, rsp_nest_depth};
   assign idle_zero   = (rsp_out_callback == 16'd0) && (rsp_out_argument == 32'd0) &&
                        (rsp_out_priority == 8'd0);
   assign dispatch_ok = (rsp_status == ppq_pkg::ST_OK) && (rsp_nest_depth != 4'd0);
   assign counts_ok   = (rsp_pending_count <= 5'(ppq_pkg::QUEUE_DEPTH)) &&
                        (rsp_nest_depth <= 4'(ppq_pkg::NEST_DEPTH));

   `ASSERT_RST(a_rsp_hold, clock, reset, stalled |=> rsp_valid && $stable(rsp_word))
   `ASSERT_RST(a_idle_fields_zero, clock, reset, rsp_valid && !rsp_dispatched |-> idle_zero)
   `ASSERT_RST(a_dispatch_ok, clock, reset, rsp_valid && rsp_dispatched |-> dispatch_ok)
   `ASSERT_RST(a_counts_bound, clock, reset, rsp_valid |-> counts_ok)

endmodule

bind preemptive_priority_task_queue ppq_checker u_ppq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_dispatched    (rsp_dispatched),
   .rsp_out_callback  (rsp_out_callback),
   .rsp_out_argument  (rsp_out_argument),
   .rsp_out_priority  (rsp_out_priority),
   .rsp_pending_count (rsp_pending_count),
   .rsp_nest_depth    (rsp_nest_depth)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the preemptive priority task queue. A directed
// table covers the empty, full, tie and idle corners, then bursts of nested
// dispatches, queue fills, drains and noise run against an in-bench
// scheduler predictor, with random gaps on both the request and result sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int REQUEST_TARGET = 1950;
   localparam int DIRECTED_ROWS  = 25;
   localparam int PRIO_MASK      = (1 << ppq_pkg::PRIO_BITS) - 1;

   typedef struct packed {
      ppq_pkg::req_code_type kind;
      logic [15:0]           cb;
      logic [31:0]           arg;
      logic [7:0]            prio;
   } task_request_type;

   typedef struct packed {
      ppq_pkg::status_code_type status;
      logic                     dispatched;
      logic [15:0]              cb;
      logic [31:0]              arg;
      logic [7:0]               prio;
      logic [4:0]               pending;
      logic [3:0]               depth;
   } sched_outcome_type;

   typedef struct packed {
      task_request_type  req;
      logic              typed;
      sched_outcome_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = ppq_pkg::REQ_ADD;
   logic [15:0] req_callback_id = '0;
   logic [31:0] req_task_argument = '0;
   logic [7:0]  req_task_priority = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_dispatched;
   logic [15:0] rsp_out_callback;
   logic [31:0] rsp_out_argument;
   logic [7:0]  rsp_out_priority;
   logic [4:0]  rsp_pending_count;
   logic [3:0]  rsp_nest_depth;

   // scheduler state as predicted
   logic [7:0]  queued_prio  [ppq_pkg::QUEUE_DEPTH];
   logic [15:0] queued_cb    [ppq_pkg::QUEUE_DEPTH];
   logic [31:0] queued_arg   [ppq_pkg::QUEUE_DEPTH];
   int          queued_count = 0;
   logic [7:0]  running_prio [ppq_pkg::NEST_DEPTH];
   int          running_count = 0;

   sched_outcome_type expected_outcomes [$];

   bit sender_eager = 1'b0;
   bit rsp_eager = 1'b0;
   int stall_left = 0;
   int mismatches = 0;
   int n_requests = 0;
   int n_dispatched = 0;
   int n_queue_full = 0;
   int n_stack_full = 0;
   int n_idle_finish = 0;
   int deepest = 0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{ppq_pkg::REQ_FINISH, 16'h0000, 32'h0000_0000, 8'h00}, 1'b1,
        '{ppq_pkg::ST_NONE_RUN, 1'b0, 16'h0, 32'h0, 8'h0, 5'd0, 4'd0}},
      '{'{ppq_pkg::REQ_DISPATCH, 16'h0000, 32'h0000_0000, 8'h00}, 1'b1,
        '{ppq_pkg::ST_OK, 1'b0, 16'h0, 32'h0, 8'h0, 5'd0, 4'd0}},
      '{'{ppq_pkg::REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b1,
        '{ppq_pkg::ST_OK, 1'b0, 16'h0, 32'h0, 8'h0, 5'd0, 4'd0}},
      '{'{ppq_pkg::REQ_ADD, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b1,
        '{ppq_pkg::ST_OK, 1'b0, 16'h0, 32'h0, 8'h0, 5'd1, 4'd0}},
      '{'{ppq_pkg::REQ_ADD, 16'h0000, 32'h0000_0000, 8'h00}, 1'b1,
        '{ppq_pkg::ST_OK, 1'b0, 16'h0, 32'h0, 8'h0, 5'd2, 4'd0}},
      '{'{ppq_pkg::REQ_ADD, 16'h0001, 32'h0000_0001, 8'h00}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h8000, 32'h8000_0000, 8'h80}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h5555, 32'h5555_5555, 8'h55}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'hAAAA, 32'hAAAA_AAAA, 8'hAA}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h0002, 32'h1234_5678, 8'hFF}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h7FFF, 32'h7FFF_FFFF, 8'h7F}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h00FF, 32'h0000_FFFF, 8'h01}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'hFF00, 32'hFFFF_0000, 8'hFE}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h0F0F, 32'h0F0F_0F0F, 8'h10}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'hF0F0, 32'hF0F0_F0F0, 8'h80}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h3C3C, 32'hC3C3_C3C3, 8'h40}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h0003, 32'h0000_0003, 8'h00}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h1111, 32'hDEAD_BEEF, 8'h20}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h2222, 32'hCAFE_F00D, 8'h02}, 1'b0, '0},
      '{'{ppq_pkg::REQ_ADD, 16'h9999, 32'h9999_9999, 8'h00}, 1'b1,
        '{ppq_pkg::ST_QUEUE_FULL, 1'b0, 16'h0, 32'h0, 8'h0, 5'd16, 4'd0}},
      '{'{ppq_pkg::REQ_DISPATCH, 16'h0000, 32'h0000_0000, 8'h00}, 1'b1,
        '{ppq_pkg::ST_OK, 1'b1, 16'h0000, 32'h0000_0000, 8'h00, 5'd15, 4'd1}},
      '{'{ppq_pkg::REQ_DISPATCH, 16'h0000, 32'h0000_0000, 8'h00}, 1'b0, '0},
      '{'{ppq_pkg::REQ_FINISH, 16'h0000, 32'h0000_0000, 8'h00}, 1'b0, '0},
      '{'{ppq_pkg::REQ_FINISH, 16'h0000, 32'h0000_0000, 8'h00}, 1'b1,
        '{ppq_pkg::ST_NONE_RUN, 1'b0, 16'h0, 32'h0, 8'h0, 5'd15, 4'd0}},
      '{'{ppq_pkg::REQ_DISPATCH, 16'h0000, 32'h0000_0000, 8'h00}, 1'b0, '0}
   };

   preemptive_priority_task_queue i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_callback_id   (req_callback_id),
      .req_task_argument (req_task_argument),
      .req_task_priority (req_task_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_dispatched    (rsp_dispatched),
      .rsp_out_callback  (rsp_out_callback),
      .rsp_out_argument  (rsp_out_argument),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_pending_count (rsp_pending_count),
      .rsp_nest_depth    (rsp_nest_depth)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sched_outcome_type scheduler_outcome(task_request_type rq);
      sched_outcome_type o;
      logic [7:0]        p;
      int                pos;
      int                i;
      o = '0;
      o.status = ppq_pkg::ST_OK;
      p = rq.prio & 8'(PRIO_MASK);
      case (rq.kind)
         ppq_pkg::REQ_ADD: begin
            if (queued_count >= ppq_pkg::QUEUE_DEPTH) begin
               o.status = ppq_pkg::ST_QUEUE_FULL;
            end else begin
               pos = 0;
               while (pos < queued_count && !(p < queued_prio[pos]))
                  pos++;
               for (i = queued_count; i > pos; i--) begin
                  queued_prio[i] = queued_prio[i - 1];
                  queued_cb[i]   = queued_cb[i - 1];
                  queued_arg[i]  = queued_arg[i - 1];
               end
               queued_prio[pos] = p;
               queued_cb[pos]   = rq.cb;
               queued_arg[pos]  = rq.arg;
               queued_count++;
            end
         end
         ppq_pkg::REQ_DISPATCH: begin
            if (queued_count > 0 && (running_count == 0 ||
                queued_prio[0] < running_prio[running_count - 1])) begin
               if (running_count >= ppq_pkg::NEST_DEPTH) begin
                  o.status = ppq_pkg::ST_STACK_FULL;
               end else begin
                  o.dispatched = 1'b1;
                  o.cb   = queued_cb[0];
                  o.arg  = queued_arg[0];
                  o.prio = queued_prio[0];
                  running_prio[running_count] = queued_prio[0];
                  running_count++;
                  for (i = 1; i < queued_count; i++) begin
                     queued_prio[i - 1] = queued_prio[i];
                     queued_cb[i - 1]   = queued_cb[i];
                     queued_arg[i - 1]  = queued_arg[i];
                  end
                  queued_count--;
               end
            end
         end
         ppq_pkg::REQ_FINISH: begin
            if (running_count == 0)
               o.status = ppq_pkg::ST_NONE_RUN;
            else
               running_count--;
         end
         default: begin
         end
      endcase
      o.pending = 5'(queued_count);
      o.depth   = 4'(running_count);
      return o;
   endfunction

   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic task_request_type make_request(ppq_pkg::req_code_type k,
                                                     logic [7:0] p);
      task_request_type rq;
      rq.kind = k;
      rq.cb   = 16'($urandom);
      rq.arg  = $urandom;
      rq.prio = p;
      return rq;
   endfunction

   task automatic send_request(task_request_type rq, logic typed, sched_outcome_type want);
      int                idle;
      sched_outcome_type predicted;
      idle = sender_eager ? 0 : gap_cycles();
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= rq.kind;
      req_callback_id   <= rq.cb;
      req_task_argument <= rq.arg;
      req_task_priority <= rq.prio;
      do @(posedge clock); while (!req_ready);
      predicted = scheduler_outcome(rq);
      expected_outcomes.push_back(typed ? want : predicted);
      if (rq.kind != ppq_pkg::REQ_UNUSED)
         n_requests++;
      if (predicted.dispatched)
         n_dispatched++;
      if (predicted.status == ppq_pkg::ST_QUEUE_FULL)
         n_queue_full++;
      if (predicted.status == ppq_pkg::ST_STACK_FULL)
         n_stack_full++;
      if (predicted.status == ppq_pkg::ST_NONE_RUN)
         n_idle_finish++;
      if (predicted.depth > deepest)
         deepest = predicted.depth;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 100)
            $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // result side: random stalls, with stretches of constant readiness
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!rsp_eager && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = gap_cycles();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      sched_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            $error("result transfer with no request outstanding");
         end else begin
            want = expected_outcomes.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("dispatched", want.dispatched, rsp_dispatched);
            check_field("out_callback", want.cb, rsp_out_callback);
            check_field("out_argument", want.arg, rsp_out_argument);
            check_field("out_priority", want.prio, rsp_out_priority);
            check_field("pending_count", want.pending, rsp_pending_count);
            check_field("nest_depth", want.depth, rsp_nest_depth);
         end
      end
   end

   initial begin
      int row;
      int burst;
      int ceiling;
      int step;
      int base;
      bit narrow;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++)
         send_request(directed_rows[row].req, directed_rows[row].typed,
                      directed_rows[row].want);
      wait_until_drained();

      while (n_requests < REQUEST_TARGET) begin
         sender_eager = ($urandom_range(0, 3) == 0);
         rsp_eager <= ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // nest: each new task undercuts the innermost running one
               burst = $urandom_range(3, 10);
               repeat (burst) begin
                  ceiling = (running_count > 0) ? running_prio[running_count - 1] : 256;
                  if (ceiling == 0) begin
                     send_request(make_request(ppq_pkg::REQ_FINISH, 8'($urandom)),
                                  1'b0, '0);
                  end else begin
                     step = $urandom_range(1, 40);
                     send_request(make_request(ppq_pkg::REQ_ADD,
                                  (ceiling > step) ? 8'(ceiling - step) : 8'd0), 1'b0, '0);
                     send_request(make_request(ppq_pkg::REQ_DISPATCH, 8'($urandom)),
                                  1'b0, '0);
                  end
               end
            end
            3, 4: begin
               burst = $urandom_range(2, 20);
               narrow = ($urandom_range(0, 2) == 0);
               base = $urandom_range(0, 254);
               repeat (burst)
                  send_request(make_request(ppq_pkg::REQ_ADD, narrow ?
                               8'(base + $urandom_range(0, 1)) : 8'($urandom)), 1'b0, '0);
            end
            5, 6: begin
               // unwind the stack, overshooting a little, then dispatch and finish up to 16 queued tasks
               repeat (running_count + $urandom_range(1, 2))
                  send_request(make_request(ppq_pkg::REQ_FINISH, 8'($urandom)), 1'b0, '0);
               burst = $urandom_range(1, 16);
               while (queued_count > 0 && burst > 0) begin
                  send_request(make_request(ppq_pkg::REQ_DISPATCH, 8'($urandom)),
                               1'b0, '0);
                  send_request(make_request(ppq_pkg::REQ_FINISH, 8'($urandom)), 1'b0, '0);
                  burst--;
               end
            end
            7: begin
               repeat ($urandom_range(1, 8))
                  send_request(make_request(ppq_pkg::req_code_type'($urandom_range(0, 3)),
                               8'($urandom)), 1'b0, '0);
            end
            default: begin
               repeat ($urandom_range(4, 16))
                  send_request(make_request(ppq_pkg::req_code_type'($urandom_range(0, 2)),
                               8'($urandom)), 1'b0, '0);
            end
         endcase
         if ($urandom_range(0, 9) == 0)
            wait_until_drained();
      end

      wait_until_drained();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests: %0d dispatches, %0d queue full,",
               n_requests, n_dispatched, n_queue_full);
      $display("%0d stack full, %0d idle finishes, deepest nesting %0d of %0d",
               n_stack_full, n_idle_finish, deepest, ppq_pkg::NEST_DEPTH);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout");
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- preemptive_priority_task_queue.f -----
+incdir+hw/rtl
hw/rtl/ppq_pkg.sv
hw/rtl/ppq_ctrl.sv
hw/rtl/ppq_dpath.sv
hw/rtl/preemptive_priority_task_queue.sv
hw/rtl/ppq_checker.sv
verif/testbench.sv
